// ----- hdl/yuvds_pkg.sv -----
package yuvds_pkg;

    // Field and register widths
    localparam int PIX_W      = 8;
    localparam int SUM_W      = 9;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_SIZE_W = 11;
    localparam int DIV_W      = 4;
    localparam int ROW_W      = 10;
    localparam int ROW_LIMIT  = 1024;
    localparam int DIV_MIN    = 2;

    // Register indexes (word address paddr[3:2])
    localparam logic [1:0] REG_BLOCK_COLUMNS = 2'd0;
    localparam logic [1:0] REG_BLOCK_ROWS    = 2'd1;
    localparam logic [1:0] REG_DIVIDER       = 2'd2;

    // Register reset values
    localparam logic [CFG_SIZE_W-1:0] RST_BLOCK_COLUMNS = 11'd320;
    localparam logic [CFG_SIZE_W-1:0] RST_BLOCK_ROWS    = 11'd240;
    localparam logic [DIV_W-1:0]      RST_DIVIDER       = 4'd2;

    typedef struct packed {
        logic [PIX_W-1:0] luma_top_left;
        logic [PIX_W-1:0] luma_top_right;
        logic [PIX_W-1:0] luma_bottom_left;
        logic [PIX_W-1:0] luma_bottom_right;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] chroma_red;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] out_luma_top_left;
        logic [PIX_W-1:0] out_luma_top_right;
        logic [PIX_W-1:0] out_luma_bottom_left;
        logic [PIX_W-1:0] out_luma_bottom_right;
        logic [PIX_W-1:0] out_chroma_blue;
        logic [PIX_W-1:0] out_chroma_red;
        logic             frame_done;
    } t_out_item;

    // One line store entry: partial result of an upper-row group
    typedef struct packed {
        logic [SUM_W-1:0] cr_sum;
        logic [SUM_W-1:0] cb_sum;
        logic [PIX_W-1:0] right_mean;
        logic [PIX_W-1:0] left_mean;
    } t_store_entry;

    // Position decode handed from the controller to the datapath
    typedef struct packed {
        logic busy;
        logic in_window;
        logic right_col;
        logic lower_row;
        logic last_group;
    } t_ctrl_status;

endpackage

// ----- hdl/yuvds_sdiv.sv -----
// Restoring divider by a small divisor, one quotient bit per step
module yuvds_sdiv import yuvds_pkg::*; #(
    parameter int W = 11
) (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic             i_step,
    input  logic [W-1:0]     i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic [W-1:0]     o_quotient,
    output logic [DIV_W-1:0] o_remainder
);

    logic [W-1:0]     r_quot;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;
    logic [DIV_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {r_rem, r_quot[W-1]};
    assign fits   = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (i_step) begin
            r_quot <= {r_quot[W-2:0], fits};
            r_rem  <= fits ? DIV_W'(rem_sh - {1'b0, r_div}) : rem_sh[DIV_W-1:0];
        end
    end

    assign o_quotient  = r_quot;
    assign o_remainder = r_rem;

endmodule

// ----- hdl/yuvds_line_store.sv -----
// Upper block row partial results, one write and one registered read port
module yuvds_line_store import yuvds_pkg::*; #(
    parameter int DEPTH = 512,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic         i_clk,
    input  logic         i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_store_entry i_wr_data,
    input  logic         i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_store_entry o_rd_data
);

    t_store_entry r_mem [DEPTH];
    t_store_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/yuvds_ctrl.sv -----
// Configuration registers, block position counters and group decode
module yuvds_ctrl import yuvds_pkg::*; #(
    parameter int MAX_BLOCK_COLUMNS = 1024,
    localparam int XW = $clog2(MAX_BLOCK_COLUMNS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    input  logic                  i_advance,
    output t_ctrl_status          o_status,
    output logic [XW-1:0]         o_group
);

    localparam int CW     = $clog2(MAX_BLOCK_COLUMNS + 1);
    localparam int LW     = (CW > CFG_SIZE_W) ? CW : CFG_SIZE_W;
    localparam int STEP_W = $clog2(LW + 1);

    logic [CFG_SIZE_W-1:0] r_block_columns;
    logic [CFG_SIZE_W-1:0] r_block_rows;
    logic [DIV_W-1:0]      r_divider;

    logic              r_load;
    logic [STEP_W-1:0] r_cnt;
    logic              r_apply;

    logic [XW-1:0]    r_col, n_col;
    logic [XW-1:0]    r_gi, n_gi;
    logic [DIV_W-1:0] r_ci, n_ci;
    logic [ROW_W-1:0] r_row, n_row;
    logic [ROW_W-1:0] r_gj, n_gj;
    logic [DIV_W-1:0] r_rj, n_rj;

    logic             cfg_wr;
    logic [LW-1:0]    cols_wide, rows_wide;
    logic [LW-1:0]    cols_eff, rows_eff;
    logic [DIV_W-1:0] div_eff;
    logic             last_col, last_row;

    logic [LW-1:0]    q_col, q_row, q_cols, q_rows;
    logic [DIV_W-1:0] m_col, m_row, m_cols, m_rows;
    logic [XW-1:0]    groups_x;
    logic [ROW_W-1:0] groups_y;

    // APB write and read
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_columns <= RST_BLOCK_COLUMNS;
            r_block_rows    <= RST_BLOCK_ROWS;
            r_divider       <= RST_DIVIDER;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_BLOCK_COLUMNS: r_block_columns <= pwdata[CFG_SIZE_W-1:0];
                REG_BLOCK_ROWS:    r_block_rows    <= pwdata[CFG_SIZE_W-1:0];
                REG_DIVIDER:       r_divider       <= pwdata[DIV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BLOCK_COLUMNS: prdata = CFG_DATA_W'(r_block_columns);
            REG_BLOCK_ROWS:    prdata = CFG_DATA_W'(r_block_rows);
            REG_DIVIDER:       prdata = CFG_DATA_W'(r_divider);
            default:           prdata = '0;
        endcase
    end

    // Effective sizes after clamping
    assign cols_wide = LW'(r_block_columns);
    assign rows_wide = LW'(r_block_rows);

    always_comb begin
        if (cols_wide == '0) begin
            cols_eff = LW'(1);
        end else if (cols_wide > LW'(MAX_BLOCK_COLUMNS)) begin
            cols_eff = LW'(MAX_BLOCK_COLUMNS);
        end else begin
            cols_eff = cols_wide;
        end
        if (rows_wide == '0) begin
            rows_eff = LW'(1);
        end else if (rows_wide > LW'(ROW_LIMIT)) begin
            rows_eff = LW'(ROW_LIMIT);
        end else begin
            rows_eff = rows_wide;
        end
        div_eff = (r_divider < DIV_W'(DIV_MIN)) ? DIV_W'(DIV_MIN) : r_divider;
    end

    // Resync sequencer: after reset and after every register write the
    // group indexes and group counts are recomputed by serial division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load  <= 1'b1;
            r_cnt   <= '0;
            r_apply <= 1'b0;
        end else begin
            r_apply <= 1'b0;
            if (r_load) begin
                r_load <= 1'b0;
                r_cnt  <= STEP_W'(LW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_apply <= 1'b1;
                end
            end
            if (cfg_wr) begin
                r_load <= 1'b1;
            end
        end
    end

    yuvds_sdiv #(.W(LW)) u_div_col (
        .i_clk(i_clk), .i_load(r_load), .i_step(r_cnt != '0),
        .i_dividend(LW'(r_col)), .i_divisor(div_eff),
        .o_quotient(q_col), .o_remainder(m_col)
    );

    yuvds_sdiv #(.W(LW)) u_div_row (
        .i_clk(i_clk), .i_load(r_load), .i_step(r_cnt != '0),
        .i_dividend(LW'(r_row)), .i_divisor(div_eff),
        .o_quotient(q_row), .o_remainder(m_row)
    );

    yuvds_sdiv #(.W(LW)) u_div_cols (
        .i_clk(i_clk), .i_load(r_load), .i_step(r_cnt != '0),
        .i_dividend(cols_eff), .i_divisor(div_eff),
        .o_quotient(q_cols), .o_remainder(m_cols)
    );

    yuvds_sdiv #(.W(LW)) u_div_rows (
        .i_clk(i_clk), .i_load(r_load), .i_step(r_cnt != '0),
        .i_dividend(rows_eff), .i_divisor(div_eff),
        .o_quotient(q_rows), .o_remainder(m_rows)
    );

    // group counts hold between resyncs; remainders of the sizes are not needed
    assign groups_x = q_cols[XW-1:0] | XW'(m_cols & '0);
    assign groups_y = q_rows[ROW_W-1:0] | ROW_W'(m_rows & '0);

    // Position step on each accepted block
    assign last_col = (LW'(r_col) + LW'(1)) >= cols_eff;
    assign last_row = (LW'(r_row) + LW'(1)) >= rows_eff;

    always_comb begin
        n_col = r_col;
        n_gi  = r_gi;
        n_ci  = r_ci;
        n_row = r_row;
        n_gj  = r_gj;
        n_rj  = r_rj;
        if (r_apply) begin
            n_gi = q_col[XW-1:0];
            n_ci = m_col;
            n_gj = q_row[ROW_W-1:0];
            n_rj = m_row;
        end else if (i_advance) begin
            if (last_col) begin
                n_col = '0;
                n_gi  = '0;
                n_ci  = '0;
                if (last_row) begin
                    n_row = '0;
                    n_gj  = '0;
                    n_rj  = '0;
                end else begin
                    n_row = r_row + 1'b1;
                    if (DIV_W'(r_rj + 1'b1) == div_eff) begin
                        n_rj = '0;
                        n_gj = r_gj + 1'b1;
                    end else begin
                        n_rj = r_rj + 1'b1;
                    end
                end
            end else begin
                n_col = r_col + 1'b1;
                if (DIV_W'(r_ci + 1'b1) == div_eff) begin
                    n_ci = '0;
                    n_gi = r_gi + 1'b1;
                end else begin
                    n_ci = r_ci + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_gi  <= '0;
            r_ci  <= '0;
            r_row <= '0;
            r_gj  <= '0;
            r_rj  <= '0;
        end else begin
            r_col <= n_col;
            r_gi  <= n_gi;
            r_ci  <= n_ci;
            r_row <= n_row;
            r_gj  <= n_gj;
            r_rj  <= n_rj;
        end
    end

    // Group decode for the datapath
    assign o_status.busy       = r_load || (r_cnt != '0) || r_apply;
    assign o_status.in_window  = (r_gi < groups_x) && (r_gj < groups_y)
                                 && (r_ci < DIV_W'(2)) && (r_rj < DIV_W'(2));
    assign o_status.right_col  = r_ci == DIV_W'(1);
    assign o_status.lower_row  = r_rj == DIV_W'(1);
    assign o_status.last_group = ((XW + 1)'(r_gi) + 1'b1 == (XW + 1)'(groups_x))
                                 && ((ROW_W + 1)'(r_gj) + 1'b1 == (ROW_W + 1)'(groups_y));
    assign o_group = r_gi;

endmodule

// ----- hdl/yuvds_block_downscale_top.sv -----
// 2x2 box downscale of a raster stream of 4:2:0 blocks. Blocks are taken at
// one per clock while o_in_stall is low; a result is presented after the
// bottom-right block of a used 2x2 group is accepted, through the line store
// read and stage 1 registers, then the output register. After reset and
// after every register write the block stalls its input while a bit-serial
// divider recomputes the group position and group counts for the new
// divider and frame size. The line store holds one entry per group column
// and needs no clearing: every entry is written on the upper block row
// before the lower row reads it.
module yuv420_block_downscale_top import yuvds_pkg::*; #(
    parameter int MAX_BLOCK_COLUMNS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int XW    = $clog2(MAX_BLOCK_COLUMNS);
    localparam int DEPTH = MAX_BLOCK_COLUMNS / 2;
    localparam int AW    = $clog2(DEPTH);

    t_ctrl_status  status;
    logic [XW-1:0] group;

    logic          in_acc;
    logic          out_free;
    logic          s1_free;
    logic [PIX_W+1:0] luma_sum;
    logic [PIX_W-1:0] mean;
    logic          take_left;
    logic          store_wr;
    logic          store_rd;
    t_store_entry  wr_entry;
    t_store_entry  rd_entry;

    logic [23:0]      r_held;
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_left_mean;
    logic [PIX_W-1:0] r_s1_right_mean;
    logic [SUM_W-1:0] r_s1_cb;
    logic [SUM_W-1:0] r_s1_cr;
    logic             r_s1_done;
    logic             r_out_valid;
    t_out_item        r_out_data;
    t_out_item        n_out_data;
    logic [SUM_W:0]   cb_total, cr_total;

    assign pready = 1'b1;

    yuvds_ctrl #(.MAX_BLOCK_COLUMNS(MAX_BLOCK_COLUMNS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .i_advance(in_acc), .o_status(status), .o_group(group)
    );

    // Handshake: the output register and stage 1 part the two sides
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1_valid || out_free;
    assign o_in_stall = status.busy || !s1_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Block mean and decode of the accepted transaction
    assign luma_sum = (PIX_W + 2)'(i_in_data.luma_top_left)
                    + (PIX_W + 2)'(i_in_data.luma_top_right)
                    + (PIX_W + 2)'(i_in_data.luma_bottom_left)
                    + (PIX_W + 2)'(i_in_data.luma_bottom_right);
    assign mean     = luma_sum[PIX_W+1:2];

    assign take_left = in_acc && status.in_window && !status.right_col;
    assign store_wr  = in_acc && status.in_window && status.right_col && !status.lower_row;
    assign store_rd  = in_acc && status.in_window && status.right_col && status.lower_row;

    assign wr_entry.left_mean  = r_held[7:0];
    assign wr_entry.right_mean = mean;
    assign wr_entry.cb_sum     = SUM_W'(r_held[15:8]) + SUM_W'(i_in_data.chroma_blue);
    assign wr_entry.cr_sum     = SUM_W'(r_held[23:16]) + SUM_W'(i_in_data.chroma_red);

    yuvds_line_store #(.DEPTH(DEPTH)) u_store (
        .i_clk(i_clk),
        .i_wr_en(store_wr), .i_wr_addr(group[AW-1:0]), .i_wr_data(wr_entry),
        .i_rd_en(store_rd), .i_rd_addr(group[AW-1:0]), .o_rd_data(rd_entry)
    );

    // Left block of the current 2x2: mean luma, Cb, Cr
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (take_left) begin
            r_held <= {i_in_data.chroma_red, i_in_data.chroma_blue, mean};
        end
    end

    // Stage 1: lower-row half, waits for the store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= store_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_rd) begin
            r_s1_left_mean  <= r_held[7:0];
            r_s1_right_mean <= mean;
            r_s1_cb         <= wr_entry.cb_sum;
            r_s1_cr         <= wr_entry.cr_sum;
            r_s1_done       <= status.last_group;
        end
    end

    // Merge with the upper-row entry
    assign cb_total = (SUM_W + 1)'(rd_entry.cb_sum) + (SUM_W + 1)'(r_s1_cb);
    assign cr_total = (SUM_W + 1)'(rd_entry.cr_sum) + (SUM_W + 1)'(r_s1_cr);

    always_comb begin
        n_out_data.out_luma_top_left     = rd_entry.left_mean;
        n_out_data.out_luma_top_right    = rd_entry.right_mean;
        n_out_data.out_luma_bottom_left  = r_s1_left_mean;
        n_out_data.out_luma_bottom_right = r_s1_right_mean;
        n_out_data.out_chroma_blue       = cb_total[SUM_W:2];
        n_out_data.out_chroma_red        = cr_total[SUM_W:2];
        n_out_data.frame_done            = r_s1_done;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
